// ===== rtl/tprx_pkg.sv =====
package tprx_pkg;

	// Widths of the item fields.
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned SIZE_W   = 11;
	localparam int unsigned OC_W     = 3;
	localparam int unsigned WORD_W   = 56;
	localparam int unsigned PKT_W    = 9;
	localparam int unsigned IN_DW    = 88;
	localparam int unsigned OUT_DW   = 56;
	localparam int unsigned CFG_IW   = 3;

	localparam int unsigned MAX_PACKETS_DEF = 255;

	// Result kinds.
	localparam logic [OC_W-1:0] OC_STORED  = 3'd0;
	localparam logic [OC_W-1:0] OC_OOO_CTS = 3'd1;
	localparam logic [OC_W-1:0] OC_WIN_CTS = 3'd2;
	localparam logic [OC_W-1:0] OC_ACK     = 3'd3;
	localparam logic [OC_W-1:0] OC_NOACK   = 3'd4;
	localparam logic [OC_W-1:0] OC_READ    = 3'd5;

	// Request kinds.
	localparam logic REQ_DATA = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IW-1:0] CFG_TOTAL_PACKETS = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_TOTAL_SIZE    = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_MAX_CTS       = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_RTS_MODE      = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_FIRST_WINDOW  = 3'd4;

	// Register reset values.
	localparam logic [BYTE_W-1:0] RST_TOTAL_PACKETS = 8'd1;
	localparam logic [SIZE_W-1:0] RST_TOTAL_SIZE    = 11'd9;
	localparam logic [BYTE_W-1:0] RST_MAX_CTS       = 8'd255;
	localparam logic              RST_RTS_MODE      = 1'b1;
	localparam logic [BYTE_W-1:0] RST_FIRST_WINDOW  = 8'd0;

	// Byte position divided by seven: multiply by ceil(2^14 / 7) and drop 14 bits.
	// Exact for every 11-bit position.
	localparam int unsigned DIV7_SHIFT = 14;
	localparam int unsigned DIV7_MUL   = 2341;
	localparam int unsigned DIV7_PW    = SIZE_W + DIV7_SHIFT - 2;

	typedef struct packed {
		logic              en;
		logic [BYTE_W-1:0] addr;
		logic [WORD_W-1:0] data;
	} wr_req_t;

	typedef struct packed {
		logic              en;
		logic [BYTE_W-1:0] addr;
	} rd_req_t;

	typedef struct packed {
		logic [OC_W-1:0]   outcome;
		logic [BYTE_W-1:0] dest_address;
		logic [BYTE_W-1:0] cts_packet_count;
		logic [BYTE_W-1:0] cts_next_packet;
		logic [SIZE_W-1:0] ack_total_bytes;
		logic [BYTE_W-1:0] ack_total_packets;
		logic [BYTE_W-1:0] read_byte;
	} res_t;

endpackage

// ===== rtl/tprx_store.sv =====
module tprx_store #(
	parameter int unsigned MAX_PACKETS = tprx_pkg::MAX_PACKETS_DEF
) (
	input  logic                         clk,
	input  tprx_pkg::wr_req_t            wr,
	input  tprx_pkg::rd_req_t            rd,
	output logic [tprx_pkg::WORD_W-1:0]  rd_data
);
	import tprx_pkg::*;

	localparam int unsigned IDX_W = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;

	logic [WORD_W-1:0] mem [0:MAX_PACKETS-1];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[IDX_W-1:0]] <= wr.data;
		end
		if (rd.en) begin
			rd_data <= mem[rd.addr[IDX_W-1:0]];
		end
	end

endmodule

// ===== rtl/tp_rx_reassembly_top.sv =====
// Receive-side transport reassembly: data frames in, control results and read bytes out.
// Pipeline: an accepted item passes the stage-one register, then the output register
// that drives m_axis_tvalid. Throughput: one item per cycle unless m_axis_tready holds
// back the output; the packet store has one write and one read port.
// Reset: arst_n clears the session count, window budget and all valid flags at once;
// the packet store is not cleared and holds undefined words until written.
module tp_rx_reassembly_top #(
	parameter int unsigned MAX_PACKETS = tprx_pkg::MAX_PACKETS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Input stream.
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// tdata, lowest bit up: source_address[7:0], seq_number[15:8], data_byte_1[23:16],
	// data_byte_2[31:24], data_byte_3[39:32], data_byte_4[47:40], data_byte_5[55:48],
	// data_byte_6[63:56], data_byte_7[71:64], read_index[82:72], zero fill[87:83].
	input  logic [tprx_pkg::IN_DW-1:0]   s_axis_tdata,
	// tuser: req_type[0].
	input  logic                         s_axis_tuser,
	// Output stream.
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// tdata, lowest bit up: dest_address[7:0], cts_packet_count[15:8],
	// cts_next_packet[23:16], ack_total_bytes[34:24], ack_total_packets[42:35],
	// read_byte[50:43], zero fill[55:51].
	output logic [tprx_pkg::OUT_DW-1:0]  m_axis_tdata,
	// tuser: outcome[2:0].
	output logic [tprx_pkg::OC_W-1:0]    m_axis_tuser,
	// Configuration write channel.
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tprx_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [tprx_pkg::SIZE_W-1:0]  cfg_data
);
	import tprx_pkg::*;

	// Input field unpacking.
	logic              req_type;
	logic [BYTE_W-1:0] source_address;
	logic [BYTE_W-1:0] seq_number;
	logic [WORD_W-1:0] payload_word;
	logic [SIZE_W-1:0] read_index;

	assign req_type       = s_axis_tuser;
	assign source_address = s_axis_tdata[7:0];
	assign seq_number     = s_axis_tdata[15:8];
	assign payload_word   = s_axis_tdata[71:16];
	assign read_index     = s_axis_tdata[82:72];

	// Configuration registers. The write channel never stalls; the user must write registers
	// only while the block is idle, which the block itself does not enforce.
	logic [BYTE_W-1:0] total_packets_q;
	logic [SIZE_W-1:0] total_size_q;
	logic [BYTE_W-1:0] max_cts_q;
	logic              rts_mode_q;

	// Session state.
	logic [BYTE_W-1:0] rcv_count_q;
	logic [BYTE_W-1:0] window_q;

	logic cfg_fire;
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	// Pipeline control. Stage one holds an accepted item while the store read
	// completes; the output register parts it from the master side.
	logic s1_valid_q;
	logic out_valid_q;
	logic out_free;
	logic s1_move;
	logic in_fire;
	logic data_fire;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s1_move       = s1_valid_q && out_free;
	assign s_axis_tready = !s1_valid_q || out_free;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign data_fire     = in_fire && (req_type == REQ_DATA);

	// Data frame decision, all from the current session state.
	logic [BYTE_W:0]   expect_seq;
	logic              in_order;
	logic [BYTE_W-1:0] rcv_next;
	logic [BYTE_W-1:0] win_dec;
	logic              completes;
	logic              win_empty;
	logic [BYTE_W-1:0] seq_m1;
	logic              store_ok;

	assign expect_seq = {1'b0, rcv_count_q} + 9'd1;
	assign in_order   = ({1'b0, seq_number} == expect_seq);
	assign rcv_next   = rcv_count_q + 8'd1;
	assign win_dec    = (window_q != 8'd0) ? (window_q - 8'd1) : 8'd0;
	assign completes  = (rcv_next == total_packets_q);
	assign win_empty  = (win_dec == 8'd0);
	assign seq_m1     = seq_number - 8'd1;
	assign store_ok   = ({1'b0, seq_m1} < PKT_W'(MAX_PACKETS));

	// Read address: the byte position splits into packet and byte within it.
	logic [DIV7_PW-1:0] div_prod;
	logic [PKT_W-1:0]   rd_pkt;
	logic [SIZE_W:0]    rd_rem;
	logic [2:0]         rd_off;
	logic               rd_ok;

	assign div_prod = DIV7_PW'(read_index) * DIV7_PW'(DIV7_MUL);
	assign rd_pkt   = div_prod[DIV7_PW-1:DIV7_SHIFT];
	assign rd_rem   = {1'b0, read_index} - (12'({rd_pkt, 3'b000}) - 12'(rd_pkt));
	assign rd_off   = rd_rem[2:0];
	assign rd_ok    = (read_index < total_size_q) && (rd_pkt < PKT_W'(MAX_PACKETS));

	// Packet store ports.
	wr_req_t           st_wr;
	rd_req_t           st_rd;
	logic [WORD_W-1:0] st_rd_data;

	assign st_wr.en   = data_fire && in_order && store_ok;
	assign st_wr.addr = seq_m1;
	assign st_wr.data = payload_word;
	assign st_rd.en   = in_fire && (req_type == REQ_READ) && rd_ok;
	assign st_rd.addr = rd_pkt[BYTE_W-1:0];

	tprx_store #(
		.MAX_PACKETS(MAX_PACKETS)
	) u_store (
		.clk    (clk),
		.wr     (st_wr),
		.rd     (st_rd),
		.rd_data(st_rd_data)
	);

	// Result of the accepted item, before the read byte is known.
	res_t res_in;

	always_comb begin
		res_in = '0;
		if (req_type == REQ_READ) begin
			res_in.outcome = OC_READ;
		end else if (!in_order) begin
			res_in.outcome          = OC_OOO_CTS;
			res_in.dest_address     = source_address;
			res_in.cts_packet_count = window_q;
			res_in.cts_next_packet  = expect_seq[BYTE_W-1:0];
		end else if (completes) begin
			if (rts_mode_q) begin
				res_in.outcome           = OC_ACK;
				res_in.dest_address      = source_address;
				res_in.ack_total_bytes   = total_size_q;
				res_in.ack_total_packets = seq_number;
			end else begin
				res_in.outcome = OC_NOACK;
			end
		end else if (win_empty) begin
			res_in.outcome          = OC_WIN_CTS;
			res_in.dest_address     = source_address;
			res_in.cts_packet_count = max_cts_q;
			res_in.cts_next_packet  = rcv_next + 8'd1;
		end else begin
			res_in.outcome = OC_STORED;
		end
	end

	// Configuration and session state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_packets_q <= RST_TOTAL_PACKETS;
			total_size_q    <= RST_TOTAL_SIZE;
			max_cts_q       <= RST_MAX_CTS;
			rts_mode_q      <= RST_RTS_MODE;
			rcv_count_q     <= '0;
			window_q        <= RST_FIRST_WINDOW;
		end else begin
			if (cfg_fire) begin
				case (cfg_index)
					CFG_TOTAL_PACKETS: total_packets_q <= cfg_data[BYTE_W-1:0];
					CFG_TOTAL_SIZE:    total_size_q    <= cfg_data;
					CFG_MAX_CTS:       max_cts_q       <= cfg_data[BYTE_W-1:0];
					CFG_RTS_MODE:      rts_mode_q      <= cfg_data[0];
					CFG_FIRST_WINDOW:  window_q        <= cfg_data[BYTE_W-1:0];
					default: ;
				endcase
			end
			if (data_fire && in_order) begin
				if (completes) begin
					rcv_count_q <= '0;
					window_q    <= win_dec;
				end else if (win_empty) begin
					rcv_count_q <= rcv_next;
					window_q    <= max_cts_q;
				end else begin
					rcv_count_q <= rcv_next;
					window_q    <= win_dec;
				end
			end
		end
	end

	// Stage one.
	res_t       res_s1;
	logic [2:0] off_s1;
	logic       rd_ok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_fire) begin
			s1_valid_q <= 1'b1;
		end else if (s1_move) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_s1   <= res_in;
			off_s1   <= rd_off;
			rd_ok_s1 <= rd_ok;
		end
	end

	// Byte select from the store word; the read port holds while stage one stalls.
	logic [BYTE_W-1:0] sel_byte;
	res_t              res_fin;

	always_comb begin
		case (off_s1)
			3'd0:    sel_byte = st_rd_data[7:0];
			3'd1:    sel_byte = st_rd_data[15:8];
			3'd2:    sel_byte = st_rd_data[23:16];
			3'd3:    sel_byte = st_rd_data[31:24];
			3'd4:    sel_byte = st_rd_data[39:32];
			3'd5:    sel_byte = st_rd_data[47:40];
			3'd6:    sel_byte = st_rd_data[55:48];
			default: sel_byte = '0;
		endcase
		res_fin = res_s1;
		if (res_s1.outcome == OC_READ && rd_ok_s1) begin
			res_fin.read_byte = sel_byte;
		end
	end

	// Output register.
	res_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_q <= res_fin;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.outcome;
	assign m_axis_tdata  = {5'd0, out_q.read_byte, out_q.ack_total_packets,
		out_q.ack_total_bytes, out_q.cts_next_packet, out_q.cts_packet_count,
		out_q.dest_address};

`ifndef SYNTHESIS
	// A completing frame closes the session.
	a_complete_clears: assert property (@(posedge clk) disable iff (!arst_n)
		data_fire && in_order && completes |=> rcv_count_q == 8'd0)
		else $error("session count not cleared after completion");

	// A plain stored frame leaves budget behind.
	a_stored_budget: assert property (@(posedge clk) disable iff (!arst_n)
		data_fire && !cfg_fire && res_in.outcome == OC_STORED |=> window_q != 8'd0)
		else $error("stored frame left an empty window");

	// An in-order frame that does not complete advances the count by one.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		data_fire && in_order && !completes |=> rcv_count_q == $past(rcv_count_q) + 8'd1)
		else $error("session count did not advance");

	// Only read results carry a read byte.
	a_read_byte_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != OC_READ |-> m_axis_tdata[50:43] == 8'd0)
		else $error("read byte set on a control result");
`endif

endmodule

// ===== test/testbench.sv =====
module testbench;
	import tprx_pkg::*;

	// Settling time after the last result: the block answers from its output register,
	// behind the stage-one register, so this covers anything still in flight.
	localparam int unsigned SETTLE_CYCLES = 8;
	// A long receiver hold-off, long enough for the block to fill and push back.
	localparam int unsigned HOLD_CYCLES = 400;
	// Stop the random sessions once this many requests have been queued.
	localparam int unsigned RANDOM_UNTIL = 1570;
	// Worst case has both sides idling at their longest for every request, plus the
	// hold-offs and register writes; this is ample.
	localparam int unsigned CYCLE_LIMIT = 500000;

	// One request as the sender sees it. Below req, the packed order matches tdata
	// from the top down, so the payload lands with data byte 1 in its lowest byte.
	typedef struct packed {
		logic              req;
		logic [SIZE_W-1:0] read_index;
		logic [6:0][7:0]   payload;
		logic [7:0]        seq;
		logic [7:0]        src;
	} tp_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_DW-1:0]  s_axis_tdata = '0;
	logic              s_axis_tuser = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_DW-1:0] m_axis_tdata;
	logic [OC_W-1:0]   m_axis_tuser;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [SIZE_W-1:0] cfg_data = '0;

	tp_rx_reassembly_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow of the block: the session registers, the reassembly state and the
	// packet words. Register values follow the block's reset values.
	logic [7:0]        reg_total_packets = RST_TOTAL_PACKETS;
	logic [SIZE_W-1:0] reg_total_size    = RST_TOTAL_SIZE;
	logic [7:0]        reg_max_cts       = RST_MAX_CTS;
	logic              reg_rts           = RST_RTS_MODE;
	logic [7:0]        win_left          = RST_FIRST_WINDOW;
	logic [7:0]        rx_count          = 8'd0;
	logic [7:0]        peer_addr         = 8'd0;
	logic [WORD_W-1:0] pkt_words [0:254];

	// Generation side: the packet count as it will stand once everything queued
	// so far has been taken, and which packet words have been written. Reads inside
	// the store are only aimed at written words, since the store powers up undefined.
	logic [7:0] gen_count = 8'd0;
	bit         written [0:254];

	tp_item_t      requests_pending [$];
	res_t          replies_due [$];
	tp_item_t      tx_item;
	int unsigned   pushed_count = 0;
	int unsigned   accepted_count = 0;
	int unsigned   mismatches = 0;
	int unsigned   cycle_count = 0;

	// Idling style for each side: 0 never idles, 1 draws a pause for every
	// transfer, 2 mostly back to back with an occasional gap.
	int unsigned tx_mode = 1;
	int unsigned rx_mode = 1;
	int unsigned tx_pause = 0;
	int unsigned rx_pause = 0;

	// The stimulus asks for a long hold-off by bumping stall_asks; the receiver
	// counts the stretch itself and bumps stall_done once it is over.
	int unsigned stall_asks = 0;
	int unsigned stall_done = 0;
	int unsigned hold_left = 0;

	function automatic int unsigned draw_pause(input int unsigned mode);
		case (mode)
			0: return 0;
			1: return $urandom_range(0, 18);
			default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
		endcase
	endfunction

	// Work out the result the block owes for one accepted request and move the
	// shadow state along with it.
	function automatic res_t reassembly_reply(input tp_item_t it);
		res_t        r;
		int unsigned nxt;
		int unsigned pos;
		r = '0;
		if (it.req == REQ_READ) begin
			r.outcome = OC_READ;
			pos = 32'(it.read_index);
			// Past the announced size or past the store, the byte reads as zero.
			if (pos < reg_total_size && pos / 7 < 255)
				r.read_byte = pkt_words[pos / 7][8 * (pos % 7) +: 8];
			return r;
		end
		peer_addr = it.src;
		nxt = rx_count + 1;
		if (it.seq != nxt) begin
			// Out of order: ask again for the packet that is missing. Once the
			// count has reached 255 this is all that can happen, with next 0.
			r.outcome          = OC_OOO_CTS;
			r.dest_address     = peer_addr;
			r.cts_packet_count = win_left;
			r.cts_next_packet  = nxt[7:0];
			return r;
		end
		pkt_words[it.seq - 8'd1] = it.payload;
		if (win_left != 0)
			win_left = win_left - 8'd1;
		rx_count = nxt[7:0];
		if (rx_count == reg_total_packets) begin
			if (reg_rts) begin
				r.outcome           = OC_ACK;
				r.dest_address      = it.src;
				r.ack_total_bytes   = reg_total_size;
				r.ack_total_packets = it.seq;
			end else begin
				r.outcome = OC_NOACK;
			end
			rx_count  = 8'd0;
			peer_addr = 8'd0;
			return r;
		end
		if (win_left == 0) begin
			// The window is spent: grant a fresh one and reload the budget.
			r.outcome          = OC_WIN_CTS;
			r.dest_address     = it.src;
			r.cts_packet_count = reg_max_cts;
			r.cts_next_packet  = rx_count + 8'd1;
			win_left           = reg_max_cts;
			return r;
		end
		r.outcome = OC_STORED;
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] wanted);
		if (got !== wanted)
			flag_mismatch($sformatf("%s is %0h, should be %0h", name, got, wanted));
	endtask

	function automatic void push_frame(input logic [7:0] src, input logic [7:0] seq,
			input logic [63:0] payload);
		tp_item_t it;
		it.req        = REQ_DATA;
		it.read_index = SIZE_W'($urandom);
		it.payload    = payload[WORD_W-1:0];
		it.seq        = seq;
		it.src        = src;
		requests_pending.push_back(it);
		pushed_count++;
		if (int'(seq) == int'(gen_count) + 1) begin
			written[seq - 8'd1] = 1'b1;
			gen_count = seq;
			if (gen_count == reg_total_packets)
				gen_count = 8'd0;
		end
	endfunction

	function automatic void push_read(input logic [SIZE_W-1:0] idx);
		tp_item_t it;
		it.req        = REQ_READ;
		it.read_index = idx;
		it.payload    = WORD_W'({$urandom, $urandom});
		it.seq        = 8'($urandom);
		it.src        = 8'($urandom);
		requests_pending.push_back(it);
		pushed_count++;
	endfunction

	// Mostly a byte inside a packet that already holds data, otherwise an index
	// beyond the end of the store.
	function automatic logic [SIZE_W-1:0] pick_read_index();
		logic [SIZE_W-1:0] idx;
		if ($urandom_range(0, 3) != 0) begin
			for (int k = 0; k < 8; k++) begin
				idx = SIZE_W'($urandom_range(0, 1784));
				if (written[idx / 7])
					return idx;
			end
		end
		return SIZE_W'($urandom_range(1785, 2047));
	endfunction

	function automatic int unsigned pick_value(input int unsigned lo, input int unsigned hi,
			input int unsigned usual_hi);
		case ($urandom_range(0, 9))
			0: return lo;
			1: return hi;
			default: return $urandom_range(lo, usual_hi);
		endcase
	endfunction

	// Idle means every queued request has been taken and every result has come
	// back; then the block is given its settling time as well.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (accepted_count != pushed_count || replies_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register writes only ever happen with the block idle, so the shadow copy
	// is updated right at the transfer without racing any request.
	task automatic write_reg(input logic [CFG_IW-1:0] idx, input int unsigned val);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[SIZE_W-1:0];
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_TOTAL_PACKETS: reg_total_packets = val[7:0];
			CFG_TOTAL_SIZE:    reg_total_size = val[SIZE_W-1:0];
			CFG_MAX_CTS:       reg_max_cts = val[7:0];
			CFG_RTS_MODE:      reg_rts = val[0];
			CFG_FIRST_WINDOW:  win_left = val[7:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	// Sender: offers the oldest pending request, holds it until the transfer,
	// then waits out its drawn pause before offering the next one. The
	// expected result is worked out at the very edge of the transfer.
	always @(posedge clk or negedge arst_n) begin : sender
		tp_item_t nxt;
		logic     busy;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			tx_pause      <= 0;
		end else begin
			busy = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				replies_due.push_back(reassembly_reply(tx_item));
				accepted_count++;
				busy = 1'b0;
			end
			if (!busy) begin
				if (tx_pause != 0) begin
					tx_pause      <= tx_pause - 1;
					s_axis_tvalid <= 1'b0;
				end else if (requests_pending.size() != 0) begin
					nxt = requests_pending.pop_front();
					tx_item       <= nxt;
					s_axis_tdata  <= {5'b0, nxt.read_index, nxt.payload, nxt.seq, nxt.src};
					s_axis_tuser  <= nxt.req;
					s_axis_tvalid <= 1'b1;
					tx_pause      <= draw_pause(tx_mode);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result transfer against the oldest expectation and
	// decides when to be ready next. Ready never waits for valid to rise.
	always @(posedge clk or negedge arst_n) begin : receiver
		res_t        want;
		logic        took;
		int unsigned w;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left     <= 0;
			rx_pause      <= 0;
		end else begin
			took = m_axis_tvalid && m_axis_tready;
			if (took) begin
				if (replies_due.size() == 0) begin
					flag_mismatch($sformatf("result with outcome %0d and none outstanding",
						m_axis_tuser));
				end else begin
					want = replies_due.pop_front();
					check_field("outcome", 16'(m_axis_tuser), 16'(want.outcome));
					check_field("dest_address", 16'(m_axis_tdata[7:0]),
						16'(want.dest_address));
					check_field("cts_packet_count", 16'(m_axis_tdata[15:8]),
						16'(want.cts_packet_count));
					check_field("cts_next_packet", 16'(m_axis_tdata[23:16]),
						16'(want.cts_next_packet));
					check_field("ack_total_bytes", 16'(m_axis_tdata[34:24]),
						16'(want.ack_total_bytes));
					check_field("ack_total_packets", 16'(m_axis_tdata[42:35]),
						16'(want.ack_total_packets));
					check_field("read_byte", 16'(m_axis_tdata[50:43]),
						16'(want.read_byte));
					check_field("tdata fill", 16'(m_axis_tdata[55:51]), 16'd0);
				end
			end
			if (hold_left != 0) begin
				hold_left     <= hold_left - 1;
				m_axis_tready <= 1'b0;
				if (hold_left == 1)
					stall_done <= stall_done + 1;
			end else if (stall_asks != stall_done) begin
				hold_left     <= HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else if (took) begin
				w = draw_pause(rx_mode);
				rx_pause      <= w;
				m_axis_tready <= (w == 0);
			end else if (rx_pause != 0) begin
				rx_pause      <= rx_pause - 1;
				m_axis_tready <= (rx_pause == 1);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int unsigned tp;
		int unsigned hi;
		int unsigned r;
		int unsigned need;
		int unsigned budget;
		int unsigned pause_at;
		logic [7:0]  sq;
		bit          in_order_ok;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, first with the reset settings: reads past the end of the
		// store before anything is written, frames out of order at both ends of
		// the sequence range, then a one-packet session completing with an ack.
		push_read(11'd2047);
		push_read(11'd1785);
		push_frame(8'hFF, 8'd0, '0);
		push_frame(8'h00, 8'd255, '1);
		push_frame(8'hA5, 8'd1, '1);
		push_read(11'd0);
		push_read(11'd6);

		// Broadcast session of three packets with a gap in the middle, the
		// largest message size and a full first window.
		write_reg(CFG_TOTAL_PACKETS, 3);
		write_reg(CFG_TOTAL_SIZE, 1785);
		write_reg(CFG_MAX_CTS, 255);
		write_reg(CFG_RTS_MODE, 0);
		write_reg(CFG_FIRST_WINDOW, 255);
		push_frame(8'h3C, 8'd1, '0);
		push_frame(8'h3C, 8'd3, {$urandom, $urandom});
		push_frame(8'h3C, 8'd2, {$urandom, $urandom});
		push_frame(8'h3C, 8'd3, {$urandom, $urandom});
		push_read(11'd20);
		push_read(11'd0);

		// One packet per window: every frame but the last spends the window.
		write_reg(CFG_TOTAL_PACKETS, 3);
		write_reg(CFG_TOTAL_SIZE, 9);
		write_reg(CFG_MAX_CTS, 1);
		write_reg(CFG_RTS_MODE, 1);
		write_reg(CFG_FIRST_WINDOW, 1);
		push_frame(8'h81, 8'd1, {$urandom, $urandom});
		push_frame(8'h81, 8'd2, {$urandom, $urandom});
		push_frame(8'h81, 8'd3, {$urandom, $urandom});
		push_read(11'd8);
		push_read(11'd9);

		// An empty first window, then the packet total dropped below the count
		// mid-session, then raised again so the session still completes.
		write_reg(CFG_TOTAL_PACKETS, 5);
		write_reg(CFG_FIRST_WINDOW, 0);
		push_frame(8'h42, 8'd1, {$urandom, $urandom});
		push_frame(8'h42, 8'd2, {$urandom, $urandom});
		write_reg(CFG_TOTAL_PACKETS, 1);
		push_frame(8'h42, 8'd3, {$urandom, $urandom});
		write_reg(CFG_TOTAL_PACKETS, 4);
		push_frame(8'h42, 8'd4, {$urandom, $urandom});

		// A full 255-packet message with the sender going flat out while the
		// receiver holds off for a long stretch, so the block has to push back.
		write_reg(CFG_TOTAL_PACKETS, 255);
		write_reg(CFG_TOTAL_SIZE, 1785);
		write_reg(CFG_MAX_CTS, 7);
		write_reg(CFG_FIRST_WINDOW, 40);
		tx_mode = 0;
		rx_mode = 1;
		stall_asks++;
		do begin
			if ($urandom_range(0, 7) == 0)
				push_read(pick_read_index());
			else
				push_frame(8'($urandom), gen_count + 8'd1, {$urandom, $urandom});
		end while (gen_count != 0);
		repeat (6) push_read(pick_read_index());

		// Random sessions. Most frames arrive in order so sessions run to their
		// end; the rest are stray frames and reads of the message so far.
		while (pushed_count < RANDOM_UNTIL) begin
			tx_mode = $urandom_range(0, 2);
			rx_mode = $urandom_range(0, 2);
			r = $urandom_range(0, 24);
			if (gen_count != 0 && r < 17) begin
				hi = gen_count + 16;
				if (hi > 255)
					hi = 255;
				tp = $urandom_range(gen_count + 1, hi);
			end else if (r == 24) begin
				tp = 255;
			end else if (r >= 21) begin
				tp = 1;
			end else begin
				tp = $urandom_range(1, 16);
			end
			write_reg(CFG_TOTAL_PACKETS, tp);
			if ($urandom_range(0, 4) < 3)
				write_reg(CFG_TOTAL_SIZE, pick_value(9, 1785, 1785));
			if ($urandom_range(0, 4) < 3)
				write_reg(CFG_MAX_CTS, pick_value(1, 255, 12));
			if ($urandom_range(0, 4) < 3)
				write_reg(CFG_RTS_MODE, $urandom_range(0, 1));
			if ($urandom_range(0, 4) < 3)
				write_reg(CFG_FIRST_WINDOW, pick_value(0, 255, 10));

			need = (tp > gen_count) ? tp - gen_count : 12;
			budget = need + need / 3 + $urandom_range(4, 20);
			// Now and then the sender stops halfway until all results are back.
			pause_at = ($urandom_range(0, 5) == 0) ? budget / 2 : budget;
			for (int i = 0; i < budget; i++) begin
				if (i == pause_at && i != 0)
					wait_idle();
				// Never let the count reach 255 by accident: it would stay there.
				in_order_ok = gen_count < 254 || int'(reg_total_packets) == int'(gen_count) + 1;
				r = $urandom_range(0, 99);
				if (r < 70 && in_order_ok) begin
					push_frame(8'($urandom), gen_count + 8'd1, {$urandom, $urandom});
				end else if (r < 85) begin
					sq = 8'($urandom);
					if (!in_order_ok && int'(sq) == int'(gen_count) + 1)
						sq = 8'd0;
					push_frame(8'($urandom), sq, {$urandom, $urandom});
				end else begin
					push_read(pick_read_index());
				end
			end
		end

		// Last of all, with no packet total the count climbs to 255 and stays:
		// from then on every frame is out of order and asks for packet 0.
		tx_mode = 2;
		rx_mode = 2;
		write_reg(CFG_TOTAL_PACKETS, 0);
		write_reg(CFG_MAX_CTS, pick_value(1, 255, 12));
		while (gen_count != 255)
			push_frame(8'($urandom), gen_count + 8'd1, {$urandom, $urandom});
		push_frame(8'h00, 8'd0, '0);
		push_frame(8'hFF, 8'd255, '1);
		push_frame(8'h5A, 8'd1, {$urandom, $urandom});
		repeat (12) begin
			if ($urandom_range(0, 2) == 0)
				push_read(pick_read_index());
			else
				push_frame(8'($urandom), 8'($urandom), {$urandom, $urandom});
		end

		wait_idle();
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/tprx_pkg.sv
rtl/tprx_store.sv
rtl/tp_rx_reassembly_top.sv
test/testbench.sv
